### src/bmhq_pkg.sv
// Package for the binary max-heap queue: request and status codes,
// transaction structs and sizing constants. No dependencies.
package bmhq_pkg;

  localparam int DEPTH_DEF     = 32;
  localparam int KEY_WIDTH_DEF = 32;

  localparam logic [2:0] REQ_APPEND   = 3'd0;
  localparam logic [2:0] REQ_BUILD    = 3'd1;
  localparam logic [2:0] REQ_INSERT   = 3'd2;
  localparam logic [2:0] REQ_EXTRACT  = 3'd3;
  localparam logic [2:0] REQ_INCREASE = 3'd4;
  localparam logic [2:0] REQ_SORT     = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_INDEX = 2'd3;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] key_in;
    logic [4:0]         slot_index;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] key_out;
    logic [5:0]         count_out;
    logic               last_result;
  } rsp_t;

  // datapath operations
  localparam logic [3:0] OP_NONE     = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;  // latch request
  localparam logic [3:0] OP_WR_END   = 4'd2;  // store key at count, count++
  localparam logic [3:0] OP_WR_SLOT  = 4'd3;  // store key at slot, cur = slot
  localparam logic [3:0] OP_RD_A     = 4'd4;  // read cur
  localparam logic [3:0] OP_RD_B     = 4'd5;  // read first compare slot
  localparam logic [3:0] OP_RD_C     = 4'd6;  // read second compare slot
  localparam logic [3:0] OP_WR_A     = 4'd7;  // write b at cur, or c if the right child is biggest
  localparam logic [3:0] OP_WR_B     = 4'd8;  // write a at other, cur = other (not in sort phase)
  localparam logic [3:0] OP_EXT_TOP  = 4'd9;  // read root, count--
  localparam logic [3:0] OP_EXT_MOVE = 4'd10; // read last, then root = it
  localparam logic [3:0] OP_EXT_PUT  = 4'd11;
  localparam logic [3:0] OP_SET_LIM  = 4'd12; // limit = count, outer = count/2
  localparam logic [3:0] OP_STEP     = 4'd13; // outer/limit step
  localparam logic [3:0] OP_RD_EMIT  = 4'd14;
  localparam logic [3:0] OP_CLR      = 4'd15; // count = 0

  typedef struct packed {
    logic [3:0] op;
    logic       up;      // sift up (else down)
    logic       sort_ph; // sort phase step: swap root with limit-1
  } cmd_t;

  typedef struct packed {
    logic       full;
    logic       empty;
    logic       bad_idx;
    logic       cur_root;   // cur == 0
    logic       no_left;    // left child beyond limit
    logic       no_right;
    logic       up_stop;    // parent not below cur
    logic       dn_stop;    // biggest is cur
    logic       outer_zero;
    logic       lim_one;
    logic       emit_last;
  } sts_t;

endpackage

### src/bmhq_datapath.sv
// Datapath of the heap queue: key memory, index registers and comparators.
// Depends on bmhq_pkg.
module bmhq_datapath import bmhq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  req_t req,
  input  cmd_t cmd,
  output sts_t sts,
  output logic [2:0] req_type,
  output logic signed [31:0] top_key,
  output logic signed [31:0] emit_key,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [KEY_WIDTH-1:0] mem [DEPTH];
  logic signed [KEY_WIDTH-1:0] rdata, ka, kb, kc, key;
  logic [CW-1:0] cur, other, limit, outer, slot, emit_idx;
  logic [CW-1:0] l_idx, r_idx, p_idx, big;
  logic [CW:0]   l_w;
  logic [AW-1:0] raddr;
  logic          wen;
  logic [AW-1:0] waddr;
  logic signed [KEY_WIDTH-1:0] wdata;
  logic [3:0]    last_op;

  assign l_w   = {cur, 1'b1};
  assign l_idx = l_w[CW-1:0];
  assign r_idx = l_idx + CW'(1);
  assign p_idx = (cur - CW'(1)) >> 1;

  always_comb begin
    raddr = cur[AW-1:0];
    unique case (cmd.op)
      OP_RD_B:     raddr = cmd.sort_ph ? other[AW-1:0] :
                           (cmd.up ? p_idx[AW-1:0] : l_idx[AW-1:0]);
      OP_RD_C:     raddr = r_idx[AW-1:0];
      OP_EXT_TOP:  raddr = '0;
      OP_EXT_MOVE: raddr = count[AW-1:0];
      OP_RD_EMIT:  raddr = emit_idx[AW-1:0];
      default:     raddr = cur[AW-1:0];
    endcase
  end

  always_comb begin
    wen = 1'b0; waddr = cur[AW-1:0]; wdata = kb;
    unique case (cmd.op)
      OP_WR_END:  begin wen = 1'b1; waddr = count[AW-1:0]; wdata = key; end
      OP_WR_SLOT: begin wen = 1'b1; waddr = slot[AW-1:0]; wdata = key; end
      OP_WR_A:    begin
        wen = 1'b1; waddr = cur[AW-1:0];
        wdata = (cmd.up || big != r_idx) ? kb : kc;
      end
      OP_WR_B:    begin wen = 1'b1; waddr = other[AW-1:0]; wdata = ka; end
      OP_EXT_PUT: begin wen = 1'b1; waddr = '0; wdata = rdata; end
      default:    wen = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign emit_key = 32'(rdata);

  // biggest among cur (ka), left (kb), right (kc)
  always_comb begin
    big = cur;
    if (!sts.no_left && kb > ka) big = l_idx;
    if (!sts.no_right && kc > ((!sts.no_left && kb > ka) ? kb : ka)) big = r_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0; last_op <= OP_NONE;
    end else begin
      last_op <= cmd.op;
      unique case (cmd.op)
        OP_WR_END:  count <= count + CW'(1);
        OP_EXT_TOP: count <= count - CW'(1);
        OP_CLR:     count <= '0;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (last_op)
      OP_RD_A: ka <= rdata;
      OP_RD_B: kb <= rdata;
      OP_RD_C: kc <= rdata;
      OP_EXT_TOP: top_key <= 32'(rdata);
      default: ;
    endcase
    unique case (cmd.op)
      OP_LOAD: begin
        req_type <= req.req_type;
        key      <= KEY_WIDTH'(signed'(req.key_in));
        slot     <= CW'(req.slot_index);
        emit_idx <= '0;
      end
      OP_WR_END:  cur <= count;
      OP_WR_SLOT: cur <= slot;
      OP_WR_A:    if (!cmd.up) other <= big;
      OP_WR_B:    if (!cmd.sort_ph) cur <= other;
      OP_EXT_PUT: begin cur <= '0; limit <= count; end
      OP_SET_LIM: begin limit <= count; outer <= count >> 1; end
      OP_STEP: begin
        if (cmd.sort_ph) begin
          limit <= limit - CW'(1);
          cur <= '0; other <= limit - CW'(1);
        end else begin
          outer <= outer - CW'(1);
          cur <= outer - CW'(1);
        end
      end
      OP_RD_EMIT: emit_idx <= emit_idx + CW'(1);
      default: ;
    endcase
    if (cmd.op == OP_RD_B && cmd.up) other <= p_idx;
  end

  assign sts.full       = (count == CW'(DEPTH));
  assign sts.empty      = (count == '0);
  assign sts.bad_idx    = (slot >= count);
  assign sts.cur_root   = (cur == '0);
  assign sts.no_left    = (l_w >= {1'b0, limit});
  assign sts.no_right   = ({1'b0, r_idx} >= {1'b0, limit}) || (l_w >= {1'b0, limit});
  assign sts.up_stop    = !(kb < ka);
  assign sts.dn_stop    = (big == cur);
  assign sts.outer_zero = (outer == '0);
  assign sts.lim_one    = (limit <= CW'(1));
  assign sts.emit_last  = (emit_idx == limit);
endmodule

### src/bmhq_ctrl.sv
// Controller of the heap queue: sequences sifts, build, sort and output.
// Depends on bmhq_pkg.
module bmhq_ctrl import bmhq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_busy,
  input  logic [2:0] req_type,
  input  sts_t sts,
  output cmd_t cmd,
  output logic ready,
  output logic rsp_load,
  output logic [1:0] rsp_status,
  output logic rsp_key_sel,   // 1: extracted key
  output logic rsp_emit,      // 1: sorted key
  output logic rsp_last
);
  localparam logic [4:0] S_IDLE = 5'd0,  S_DEC = 5'd1,  S_UA = 5'd2,
                         S_UB = 5'd3,   S_UC = 5'd4,   S_UW = 5'd5,
                         S_UW2 = 5'd6,  S_DA = 5'd7,   S_DB = 5'd8,
                         S_DC = 5'd9,   S_DW0 = 5'd10, S_DW = 5'd11,
                         S_DW2 = 5'd12, S_XT = 5'd13,  S_XM = 5'd14,
                         S_SX = 5'd15,  S_BS = 5'd16,  S_BN = 5'd17,
                         S_SS = 5'd18,  S_SW = 5'd19,  S_EM = 5'd20,
                         S_EW = 5'd21,  S_RSP = 5'd22, S_XS = 5'd23,
                         S_SA = 5'd24,  S_SB = 5'd25;
  logic [4:0] state, state_next;
  logic       sorting, sorting_next, xtr, xtr_next;
  logic [1:0] stat, stat_next;

  assign ready = (state == S_IDLE) && !out_busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; sorting <= 1'b0; xtr <= 1'b0; stat <= ST_OK;
    end else begin
      state <= state_next; sorting <= sorting_next; xtr <= xtr_next;
      stat <= stat_next;
    end
  end

  always_comb begin
    state_next = state; sorting_next = sorting; xtr_next = xtr; stat_next = stat;
    cmd = '{op: OP_NONE, up: 1'b0, sort_ph: 1'b0};
    rsp_load = 1'b0; rsp_status = stat; rsp_key_sel = xtr; rsp_emit = 1'b0;
    rsp_last = 1'b1;
    unique case (state)
      S_IDLE: if (in_fire) begin cmd.op = OP_LOAD; state_next = S_DEC; end
      S_DEC: begin
        stat_next = ST_OK; xtr_next = 1'b0; sorting_next = 1'b0;
        unique case (req_type)
          REQ_APPEND, REQ_INSERT:
            if (sts.full) begin stat_next = ST_FULL; state_next = S_RSP; end
            else begin
              cmd.op = OP_WR_END;
              state_next = (req_type == REQ_INSERT) ? S_UA : S_RSP;
            end
          REQ_INCREASE:
            if (sts.bad_idx) begin stat_next = ST_INDEX; state_next = S_RSP; end
            else begin cmd.op = OP_WR_SLOT; state_next = S_UA; end
          REQ_EXTRACT:
            if (sts.empty) begin stat_next = ST_EMPTY; state_next = S_RSP; end
            else begin cmd.op = OP_EXT_TOP; xtr_next = 1'b1; state_next = S_XT; end
          REQ_BUILD: begin cmd.op = OP_SET_LIM; state_next = S_BN; end
          REQ_SORT:
            if (sts.empty) begin stat_next = ST_EMPTY; state_next = S_RSP; end
            else begin cmd.op = OP_SET_LIM; sorting_next = 1'b1; state_next = S_BN; end
          default: state_next = S_RSP;
        endcase
      end
      // sift up
      S_UA: if (sts.cur_root) state_next = S_RSP;
            else begin cmd.op = OP_RD_A; cmd.up = 1'b1; state_next = S_UB; end
      S_UB: begin cmd.op = OP_RD_B; cmd.up = 1'b1; state_next = S_UC; end
      S_UC: state_next = S_UW;
      S_UW: if (sts.up_stop) state_next = S_RSP;
            else begin cmd.op = OP_WR_A; cmd.up = 1'b1; state_next = S_UW2; end
      S_UW2: begin cmd.op = OP_WR_B; state_next = S_UA; end
      // extract
      S_XT: begin cmd.op = OP_EXT_MOVE; state_next = S_XM; end
      S_XM: begin cmd.op = OP_EXT_PUT; state_next = S_DA; end
      // sift down
      S_DA: begin cmd.op = OP_RD_A; state_next = S_DB; end
      S_DB: begin cmd.op = OP_RD_B; state_next = S_DC; end
      S_DC: begin cmd.op = OP_RD_C; state_next = S_DW0; end
      S_DW0: state_next = S_DW;
      S_DW: if (sts.dn_stop) state_next = xtr ? S_RSP : S_BN;
            else begin cmd.op = OP_WR_A; state_next = S_DW2; end
      S_DW2: begin cmd.op = OP_WR_B; state_next = S_DA; end
      // build loop
      S_BN: if (sts.outer_zero) state_next = sorting ? S_XS : S_RSP;
            else begin cmd.op = OP_STEP; state_next = S_BS; end
      S_BS: state_next = S_DA;
      // sort loop: swap root with limit-1, shrink, sift down
      S_XS: if (sts.lim_one) begin cmd.op = OP_SET_LIM; state_next = S_EM; end
            else begin cmd.op = OP_STEP; cmd.sort_ph = 1'b1; state_next = S_SS; end
      S_SS: begin cmd.op = OP_RD_A; state_next = S_SW; end
      S_SW: begin cmd.op = OP_RD_B; cmd.sort_ph = 1'b1; state_next = S_SX; end
      S_SX: state_next = S_SA;
      S_SA: begin cmd.op = OP_WR_A; cmd.up = 1'b1; state_next = S_SB; end
      S_SB: begin cmd.op = OP_WR_B; cmd.sort_ph = 1'b1; state_next = S_DA; end
      S_EM: if (!out_busy) begin cmd.op = OP_RD_EMIT; state_next = S_EW; end
      S_EW: begin
        rsp_load = 1'b1; rsp_emit = 1'b1; rsp_status = ST_OK;
        rsp_last = sts.emit_last;
        if (sts.emit_last) begin cmd.op = OP_CLR; state_next = S_IDLE; end
        else state_next = S_EM;
      end
      S_RSP: if (!out_busy) begin rsp_load = 1'b1; state_next = S_IDLE; end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

### src/binary_max_heap_queue.sv
// Binary max-heap priority queue of signed keys, top level.
// Instantiates bmhq_ctrl and bmhq_datapath; depends on bmhq_pkg.
//
// Input channel req (valid req_valid, stall req_stall) carries one request
// transaction: append, build, insert, extract max, increase key or sort.
// Output channel rsp (valid rsp_valid, stall rsp_stall) carries result
// transactions; each request gives one, except sort of a non-empty store,
// which gives one per key, ascending, with last_result on the final one.
// One request is worked at a time; req_stall stays high until it finishes.
// Append, unknown codes and error cases answer with no sift; a sift goes
// level by level, with reads and writes of the key memory, which has
// registered read data. The next request is taken only after the result
// is loaded, once the controller is idle and rsp is not stalled. Build
// does one sift down per parent; sort builds, then swaps the root with the
// last key and sifts down once per key but the last, and emits its keys
// one at a time. Reset clears the count and the control; stored keys stay
// undefined until written. A stall on rsp holds the result register and
// the controller waits before loading the next one.
module binary_max_heap_queue import bmhq_pkg::*; #(
  parameter int DEPTH     = DEPTH_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t cmd;
  sts_t sts;
  logic ready, rsp_load, rsp_key_sel, rsp_emit, rsp_last, in_fire, out_busy;
  logic [1:0] rsp_status;
  logic [2:0] req_type;
  logic signed [31:0] top_key, emit_key;
  logic [CW-1:0] count;

  assign req_stall = !ready;
  assign in_fire   = req_valid && ready;
  assign out_busy  = rsp_valid && rsp_stall;

  bmhq_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_busy, .req_type, .sts, .cmd, .ready,
    .rsp_load, .rsp_status, .rsp_key_sel, .rsp_emit, .rsp_last
  );

  bmhq_datapath #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) u_dp (
    .clk, .rst, .req, .cmd, .sts, .req_type, .top_key, .emit_key, .count
  );

  always_ff @(posedge clk) begin
    if (rst) rsp_valid <= 1'b0;
    else if (rsp_load) rsp_valid <= 1'b1;
    else if (!rsp_stall) rsp_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp.status      <= rsp_status;
      rsp.key_out     <= rsp_emit ? emit_key :
                         ((rsp_key_sel && rsp_status == ST_OK) ? top_key : '0);
      rsp.count_out   <= rsp_emit ? 6'd0 : 6'(count);
      rsp.last_result <= rsp_last;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |-> !rsp_load) else $error("result overwritten");
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    rsp_load |-> req_stall) else $error("ready while answering");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("count beyond depth");
endmodule

### test/binary_max_heap_queue_tb.sv
// Testbench for binary_max_heap_queue: drives request transactions from a queue,
// predicts result transactions with a behavioural heap and checks each field.
// Depends on bmhq_pkg and the binary_max_heap_queue RTL.
`timescale 1ns / 100ps

module binary_max_heap_queue_tb;
  import bmhq_pkg::*;

  localparam int CAP = DEPTH_DEF;

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  logic signed [31:0] heap_keys[CAP];
  int heap_count;
  int send_idle_pct;
  int recv_idle_pct;
  int errors;

  binary_max_heap_queue i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void push_result(logic [1:0] st, logic signed [31:0] k, int cnt,
                                      logic lst);
    rsp_t r;
    r.status = st;
    r.key_out = k;
    r.count_out = cnt[5:0];
    r.last_result = lst;
    expected_rsps.push_back(r);
  endfunction

  function automatic void swap_keys(int a, int b);
    logic signed [31:0] t;
    t = heap_keys[a];
    heap_keys[a] = heap_keys[b];
    heap_keys[b] = t;
  endfunction

  function automatic void sift_down_keys(int n, int i);
    int l;
    int r;
    int big;
    forever begin
      l = 2 * i + 1;
      r = 2 * i + 2;
      big = i;
      if (l < n && heap_keys[l] > heap_keys[big]) big = l;
      if (r < n && heap_keys[r] > heap_keys[big]) big = r;
      if (big == i) return;
      swap_keys(i, big);
      i = big;
    end
  endfunction

  function automatic void sift_up_keys(int j);
    int p;
    while (j > 0) begin
      p = (j - 1) / 2;
      if (!(heap_keys[p] < heap_keys[j])) return;
      swap_keys(p, j);
      j = p;
    end
  endfunction

  function automatic void heapify_keys(int n);
    for (int i = n / 2; i > 0; i--) sift_down_keys(n, i - 1);
  endfunction

  function automatic void predict_heap(req_t q);
    logic signed [31:0] top;
    int n;
    case (q.req_type)
      REQ_APPEND, REQ_INSERT: begin
        if (heap_count >= CAP) begin
          push_result(ST_FULL, 0, heap_count, 1'b1);
        end else begin
          heap_keys[heap_count] = q.key_in;
          heap_count++;
          if (q.req_type == REQ_INSERT) sift_up_keys(heap_count - 1);
          push_result(ST_OK, 0, heap_count, 1'b1);
        end
      end
      REQ_BUILD: begin
        heapify_keys(heap_count);
        push_result(ST_OK, 0, heap_count, 1'b1);
      end
      REQ_EXTRACT: begin
        if (heap_count == 0) begin
          push_result(ST_EMPTY, 0, 0, 1'b1);
        end else begin
          top = heap_keys[0];
          heap_count--;
          heap_keys[0] = heap_keys[heap_count];
          sift_down_keys(heap_count, 0);
          push_result(ST_OK, top, heap_count, 1'b1);
        end
      end
      REQ_INCREASE: begin
        if (q.slot_index >= heap_count) begin
          push_result(ST_INDEX, 0, heap_count, 1'b1);
        end else begin
          heap_keys[q.slot_index] = q.key_in;
          sift_up_keys(q.slot_index);
          push_result(ST_OK, 0, heap_count, 1'b1);
        end
      end
      REQ_SORT: begin
        n = heap_count;
        if (n == 0) begin
          push_result(ST_EMPTY, 0, 0, 1'b1);
        end else begin
          heapify_keys(n);
          for (int i = n - 1; i > 0; i--) begin
            swap_keys(0, i);
            sift_down_keys(i, 0);
          end
          heap_count = 0;
          for (int i = 0; i < n; i++) push_result(ST_OK, heap_keys[i], 0, i + 1 == n);
        end
      end
      default: push_result(ST_OK, 0, heap_count, 1'b1);
    endcase
  endfunction

  function automatic void add_req(logic [2:0] t, logic signed [31:0] k, logic [4:0] s);
    req_t q;
    q.req_type = t;
    q.key_in = k;
    q.slot_index = s;
    pending_reqs.push_back(q);
  endfunction

  function automatic logic signed [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return $signed($urandom_range(0, 15)) - 8;
      default: return $signed($urandom());
    endcase
  endfunction

  // Random content in mostly well-formed fill/drain sequences.
  task automatic add_random(int total);
    int made;
    int fill;
    logic [2:0] t;
    made = 0;
    while (made < total) begin
      fill = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 10);
      for (int i = 0; i < fill; i++) begin
        t = $urandom_range(0, 3) == 0 ? REQ_APPEND : REQ_INSERT;
        add_req(t, rand_key(), 5'($urandom()));
      end
      made += fill;
      repeat ($urandom_range(0, 4)) begin
        case ($urandom_range(0, 9))
          0: add_req(REQ_BUILD, rand_key(), 5'($urandom()));
          1, 2: add_req(REQ_INCREASE, rand_key(), 5'($urandom_range(0, 12)));
          3: add_req(REQ_INCREASE, rand_key(), 5'($urandom()));
          4: add_req(3'($urandom_range(6, 7)), rand_key(), 5'($urandom()));
          default: add_req(REQ_EXTRACT, rand_key(), 5'($urandom()));
        endcase
        made++;
      end
      if ($urandom_range(0, 1)) begin
        add_req(REQ_SORT, rand_key(), 5'($urandom()));
        made++;
      end else begin
        repeat (fill + 1) add_req(REQ_EXTRACT, rand_key(), 5'($urandom()));
        made += fill + 1;
      end
    end
  endtask

  // Directed start: empty-store errors, extremes, every request, unknown codes.
  task automatic add_directed();
    add_req(REQ_EXTRACT, 0, 0);
    add_req(REQ_SORT, 0, 0);
    add_req(REQ_INCREASE, 5, 0);
    add_req(REQ_BUILD, 0, 0);
    add_req(3'd6, 32'sh7fff_ffff, 5'd31);
    add_req(3'd7, 32'sh8000_0000, 5'd0);
    add_req(REQ_APPEND, 32'sh8000_0000, 5'd31);
    add_req(REQ_APPEND, 32'sh7fff_ffff, 0);
    add_req(REQ_APPEND, -1, 0);
    add_req(REQ_APPEND, 0, 0);
    add_req(REQ_INCREASE, 9, 5'd4);
    add_req(REQ_BUILD, 0, 0);
    add_req(REQ_INSERT, 1, 0);
    add_req(REQ_INCREASE, 32'sh7fff_ffff, 5'd3);
    add_req(REQ_INCREASE, 32'sh8000_0000, 5'd1);
    add_req(REQ_EXTRACT, 0, 0);
    add_req(REQ_APPEND, 7, 0);
    add_req(REQ_SORT, 0, 0);
    for (int i = 0; i < CAP; i++) add_req(REQ_APPEND, $signed($urandom()), 0);
    add_req(REQ_APPEND, 3, 0);
    add_req(REQ_INSERT, 3, 0);
    add_req(REQ_INCREASE, 4, 5'd31);
    add_req(REQ_SORT, 0, 0);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      rsp_stall <= 1'b0;
    end else begin
      rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      if (!req_valid || !req_stall) begin
        if (req_valid) predict_heap(req);
        if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req <= pending_reqs.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result %p", $time, rsp);
        errors++;
      end else begin
        rsp_t e;
        e = expected_rsps.pop_front();
        if (rsp.status !== e.status) begin
          $display("%0t: status exp %0d got %0d", $time, e.status, rsp.status);
          errors++;
        end
        if (rsp.key_out !== e.key_out) begin
          $display("%0t: key_out exp %0d got %0d", $time, e.key_out, rsp.key_out);
          errors++;
        end
        if (rsp.count_out !== e.count_out) begin
          $display("%0t: count_out exp %0d got %0d", $time, e.count_out, rsp.count_out);
          errors++;
        end
        if (rsp.last_result !== e.last_result) begin
          $display("%0t: last_result exp %0b got %0b", $time, e.last_result,
                   rsp.last_result);
          errors++;
        end
      end
    end
  end

  task automatic drain_phase();
    while (pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    rsp_stall = 1'b0;
    heap_count = 0;
    errors = 0;
    send_idle_pct = 13;
    recv_idle_pct = 76;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    add_directed();
    add_random(130);
    drain_phase();
    send_idle_pct = 76;
    recv_idle_pct = 13;
    add_random(130);
    drain_phase();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random(125);
    drain_phase();
    repeat (100) @(posedge clk);
    if (errors == 0) $display("binary_max_heap_queue_tb passed");
    else $display("binary_max_heap_queue_tb failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("binary_max_heap_queue_tb failed");
    $finish;
  end

endmodule
